@@ rtl/core/aslm_pkg.sv @@
`default_nettype none
package aslm_pkg;

   // Event codes carried in the operation field
   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_RX_PULSE   = 3'd1,
      OP_TX_PULSE   = 3'd2,
      OP_ERROR      = 3'd3,
      OP_STA_MODE   = 3'd4,
      OP_AP_MODE    = 3'd5,
      OP_STA_LINK   = 3'd6,
      OP_AP_CLIENT  = 3'd7
   } op_type;

   // Register indexes of the write port
   localparam int CSR_IDX_BITS = 1;
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_HOLD_TIME    = 1'b0,
      CSR_BLINK_PERIOD = 1'b1
   } csr_index_type;

   localparam int HOLD_TIME_BITS = 8;
   localparam int PERIOD_BITS    = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int COLOR_BITS     = 8;

   localparam logic [HOLD_TIME_BITS-1:0] HOLD_TIME_RESET    = 8'd30;
   localparam logic [PERIOD_BITS-1:0]    BLINK_PERIOD_RESET = 16'd1000;

   localparam logic [COLOR_BITS-1:0] COLOR_FULL         = 8'd255;
   localparam logic [COLOR_BITS-1:0] COLOR_ORANGE_GREEN = 8'd64;
   localparam logic [COLOR_BITS-1:0] COLOR_OFF          = 8'd0;

   localparam int HOLD_BITS_DEFAULT  = 8;
   localparam int PHASE_BITS_DEFAULT = 16;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } color_type;

endpackage
`default_nettype wire

@@ rtl/core/activity_status_led_mixer.sv @@
`default_nettype none
// Status colour mixer. Each request is one event (tick, rx/tx activity pulse or a new
// flag level) and yields exactly one colour: error red, then an orange (station mode,
// no link) or white (ap mode, no client) blink, then cyan/blue/green for rx/tx
// activity, else black. A request updates the counters and flags in the cycle it is
// accepted; the colour is then computed from them and held in the output register, and
// one request is taken every cycle as long as the result side keeps up. A stall on the
// result side backs up to req_stall only once both the output register and the
// in-flight stage hold a result. Write hold_time and blink_period only while idle.
module activity_status_led_mixer #(
   parameter int HOLD_BITS  = aslm_pkg::HOLD_BITS_DEFAULT,
   parameter int PHASE_BITS = aslm_pkg::PHASE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [aslm_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [aslm_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [2:0]                          req_operation,
   input  wire logic                                req_flag_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [aslm_pkg::COLOR_BITS-1:0]          rsp_red,
   output logic [aslm_pkg::COLOR_BITS-1:0]          rsp_green,
   output logic [aslm_pkg::COLOR_BITS-1:0]          rsp_blue
);
   import aslm_pkg::*;

   localparam int HCMP_BITS = (HOLD_BITS > HOLD_TIME_BITS) ? HOLD_BITS : HOLD_TIME_BITS;
   localparam int LCMP_BITS = (PHASE_BITS > HOLD_TIME_BITS) ? PHASE_BITS : HOLD_TIME_BITS;
   localparam int PCMP_BITS = ((PHASE_BITS > PERIOD_BITS) ? PHASE_BITS : PERIOD_BITS) + 1;

   logic [HOLD_TIME_BITS-1:0] hold_time_ff;
   logic [PERIOD_BITS-1:0]    blink_period_ff;

   logic [PHASE_BITS-1:0] blink_phase_ff, blink_phase_in;
   logic [HOLD_BITS-1:0]  rx_remaining_ff, rx_remaining_in;
   logic [HOLD_BITS-1:0]  tx_remaining_ff, tx_remaining_in;
   logic error_flag_ff, error_flag_in;
   logic sta_mode_ff, sta_mode_in;
   logic ap_mode_ff, ap_mode_in;
   logic sta_link_ff, sta_link_in;
   logic ap_client_ff, ap_client_in;

   logic      pend_ff, pend_in;
   logic      rsp_valid_ff, rsp_valid_in;
   color_type color_ff, color_in;

   logic                  req_accept;
   logic                  rsp_advance;
   op_type                op;
   logic [HCMP_BITS-1:0]  hold_wide;
   logic [HCMP_BITS-1:0]  hold_max;
   logic [HOLD_BITS-1:0]  hold_load;
   logic [PCMP_BITS-1:0]  phase_inc;
   logic [PCMP_BITS-1:0]  period_eff;
   logic                  lit;
   logic                  rx_act;
   logic                  tx_act;

   assign rsp_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = pend_ff && !rsp_advance;
   assign req_accept  = req_valid && !req_stall;
   assign op          = op_type'(req_operation);

   // Saturate the load when the hold counter is narrower than the register
   assign hold_wide = HCMP_BITS'(hold_time_ff);
   assign hold_max  = HCMP_BITS'({HOLD_BITS{1'b1}});
   assign hold_load = (hold_wide > hold_max) ? HOLD_BITS'(hold_max) : HOLD_BITS'(hold_wide);

   assign phase_inc  = PCMP_BITS'(blink_phase_ff) + PCMP_BITS'(1);
   assign period_eff = (blink_period_ff == '0) ? PCMP_BITS'(1) : PCMP_BITS'(blink_period_ff);

   always_comb begin
      blink_phase_in  = blink_phase_ff;
      rx_remaining_in = rx_remaining_ff;
      tx_remaining_in = tx_remaining_ff;
      error_flag_in   = error_flag_ff;
      sta_mode_in     = sta_mode_ff;
      ap_mode_in      = ap_mode_ff;
      sta_link_in     = sta_link_ff;
      ap_client_in    = ap_client_ff;
      if (req_accept) begin
         unique case (op)
            OP_TICK: begin
               blink_phase_in = (phase_inc >= period_eff) ? '0 : PHASE_BITS'(phase_inc);
               if (rx_remaining_ff != '0) rx_remaining_in = rx_remaining_ff - 1'b1;
               if (tx_remaining_ff != '0) tx_remaining_in = tx_remaining_ff - 1'b1;
            end
            OP_RX_PULSE: rx_remaining_in = hold_load;
            OP_TX_PULSE: tx_remaining_in = hold_load;
            OP_ERROR:    error_flag_in   = req_flag_value;
            OP_STA_MODE: begin
               sta_mode_in = req_flag_value;
               if (req_flag_value) ap_mode_in = 1'b0;
            end
            OP_AP_MODE: begin
               ap_mode_in = req_flag_value;
               if (req_flag_value) sta_mode_in = 1'b0;
            end
            OP_STA_LINK:  sta_link_in  = req_flag_value;
            OP_AP_CLIENT: ap_client_in = req_flag_value;
            default: ;
         endcase
      end
   end

   // Colour from the state left by the request accepted last
   assign lit    = LCMP_BITS'(blink_phase_ff) < LCMP_BITS'(hold_time_ff);
   assign rx_act = rx_remaining_ff != '0;
   assign tx_act = tx_remaining_ff != '0;

   always_comb begin
      color_in = '{red: COLOR_OFF, green: COLOR_OFF, blue: COLOR_OFF};
      priority if (error_flag_ff) begin
         color_in.red = COLOR_FULL;
      end else if (sta_mode_ff && !sta_link_ff && lit) begin
         color_in.red   = COLOR_FULL;
         color_in.green = COLOR_ORANGE_GREEN;
      end else if (!sta_mode_ff && ap_mode_ff && !ap_client_ff && lit) begin
         color_in = '{red: COLOR_FULL, green: COLOR_FULL, blue: COLOR_FULL};
      end else begin
         if (rx_act) color_in.blue  = COLOR_FULL;
         if (tx_act) color_in.green = COLOR_FULL;
      end
   end

   assign pend_in      = req_accept || (pend_ff && !rsp_advance);
   assign rsp_valid_in = rsp_advance ? pend_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_time_ff    <= HOLD_TIME_RESET;
         blink_period_ff <= BLINK_PERIOD_RESET;
         blink_phase_ff  <= '0;
         rx_remaining_ff <= '0;
         tx_remaining_ff <= '0;
         error_flag_ff   <= 1'b0;
         sta_mode_ff     <= 1'b0;
         ap_mode_ff      <= 1'b0;
         sta_link_ff     <= 1'b0;
         ap_client_ff    <= 1'b0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_HOLD_TIME:    hold_time_ff    <= HOLD_TIME_BITS'(csr_wdata);
               CSR_BLINK_PERIOD: blink_period_ff <= PERIOD_BITS'(csr_wdata);
               default: ;
            endcase
         end
         blink_phase_ff  <= blink_phase_in;
         rx_remaining_ff <= rx_remaining_in;
         tx_remaining_ff <= tx_remaining_in;
         error_flag_ff   <= error_flag_in;
         sta_mode_ff     <= sta_mode_in;
         ap_mode_ff      <= ap_mode_in;
         sta_link_ff     <= sta_link_in;
         ap_client_ff    <= ap_client_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_advance && pend_ff) color_ff <= color_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = color_ff.red;
   assign rsp_green = color_ff.green;
   assign rsp_blue  = color_ff.blue;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import aslm_pkg::*;

   class color_scoreboard;
      localparam int HOLD_W  = HOLD_BITS_DEFAULT;
      localparam int PHASE_W = PHASE_BITS_DEFAULT;
      localparam longint HOLD_MAX = (longint'(1) << HOLD_W) - 1;

      logic [HOLD_TIME_BITS-1:0] hold_time;
      logic [PERIOD_BITS-1:0]    blink_period;
      logic [PHASE_W-1:0]        blink_phase;
      logic [HOLD_W-1:0]         rx_remaining;
      logic [HOLD_W-1:0]         tx_remaining;
      logic error_flag, station_mode, ap_mode, station_link, ap_client_link;

      color_type expected_colors[$];
      int mismatches;
      int requests_seen;
      int colors_checked;

      function new();
         hold_time      = HOLD_TIME_RESET;
         blink_period   = BLINK_PERIOD_RESET;
         blink_phase    = '0;
         rx_remaining   = '0;
         tx_remaining   = '0;
         error_flag     = 1'b0;
         station_mode   = 1'b0;
         ap_mode        = 1'b0;
         station_link   = 1'b0;
         ap_client_link = 1'b0;
         mismatches     = 0;
         requests_seen  = 0;
         colors_checked = 0;
      endfunction

      function void set_registers(logic [HOLD_TIME_BITS-1:0] hold,
                                  logic [PERIOD_BITS-1:0] period);
         hold_time    = hold;
         blink_period = period;
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction

      function void note_request(op_type op, logic flag);
         color_type c;
         longint load;
         longint period;
         logic lit;
         // saturate the load when the hold counter is narrower than the register
         load = (longint'(hold_time) > HOLD_MAX) ? HOLD_MAX : longint'(hold_time);
         period = (blink_period == '0) ? 1 : longint'(blink_period);
         case (op)
            OP_TICK: begin
               if (longint'(blink_phase) + 1 >= period) blink_phase = '0;
               else blink_phase = blink_phase + 1'b1;
               if (rx_remaining != '0) rx_remaining = rx_remaining - 1'b1;
               if (tx_remaining != '0) tx_remaining = tx_remaining - 1'b1;
            end
            OP_RX_PULSE: rx_remaining = load[HOLD_W-1:0];
            OP_TX_PULSE: tx_remaining = load[HOLD_W-1:0];
            OP_ERROR:    error_flag = flag;
            OP_STA_MODE: begin
               station_mode = flag;
               if (flag) ap_mode = 1'b0;
            end
            OP_AP_MODE: begin
               ap_mode = flag;
               if (flag) station_mode = 1'b0;
            end
            OP_STA_LINK: station_link = flag;
            default:     ap_client_link = flag;
         endcase

         lit = (blink_phase < hold_time);
         c.red   = COLOR_OFF;
         c.green = COLOR_OFF;
         c.blue  = COLOR_OFF;
         if (error_flag) begin
            c.red = COLOR_FULL;
         end else if (station_mode && !station_link && lit) begin
            c.red   = COLOR_FULL;
            c.green = COLOR_ORANGE_GREEN;
         end else if (!station_mode && ap_mode && !ap_client_link && lit) begin
            c.red   = COLOR_FULL;
            c.green = COLOR_FULL;
            c.blue  = COLOR_FULL;
         end else begin
            if (tx_remaining != '0) c.green = COLOR_FULL;
            if (rx_remaining != '0) c.blue = COLOR_FULL;
         end
         expected_colors.push_back(c);
         requests_seen++;
      endfunction

      function void check_result(logic [COLOR_BITS-1:0] red, logic [COLOR_BITS-1:0] green,
                                 logic [COLOR_BITS-1:0] blue);
         color_type want;
         if (expected_colors.size() == 0) begin
            $error("unexpected color (%0d,%0d,%0d) with no request outstanding",
                   red, green, blue);
            mismatches++;
            return;
         end
         want = expected_colors.pop_front();
         colors_checked++;
         if (red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, red);
            mismatches++;
         end
         if (green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, green);
            mismatches++;
         end
         if (blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, blue);
            mismatches++;
         end
      endfunction
   endclass

   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 100;
   localparam int LONG_HOLD       = 60;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 2000;

   logic clock = 1'b0;
   logic reset;
   logic csr_write;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_operation;
   logic req_flag_value;
   logic rsp_valid;
   logic rsp_stall;
   logic [COLOR_BITS-1:0] rsp_red, rsp_green, rsp_blue;

   color_scoreboard board;
   bit sender_idles;
   bit receiver_idles;
   bit long_hold_pending;
   int idle_cycles = 0;
   int settings_used;

   activity_status_led_mixer #(
      .HOLD_BITS(HOLD_BITS_DEFAULT),
      .PHASE_BITS(PHASE_BITS_DEFAULT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_flag_value(req_flag_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_request(op_type'(req_operation), req_flag_value);
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_red, rsp_green, rsp_blue);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without progress", idle_cycles);
            $display("Mismatches found");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send_request(input op_type op, input logic flag);
      int gap;
      gap = sender_idles ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_flag_value <= flag;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and wait until every color of the burst is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic configure(input logic [HOLD_TIME_BITS-1:0] hold,
                            input logic [PERIOD_BITS-1:0] period);
      csr_write <= 1'b1;
      csr_index <= CSR_HOLD_TIME;
      // junk in the upper bits must be dropped by the 8-bit register
      csr_wdata <= {8'($urandom), hold};
      @(posedge clock);
      csr_index <= CSR_BLINK_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_write <= 1'b0;
      board.set_registers(hold, period);
      settings_used++;
   endtask

   task automatic send_random_event();
      int pick;
      op_type op;
      logic flag;
      pick = $urandom_range(0, 9);
      if (pick < 4) op = OP_TICK;
      else if (pick == 4) op = OP_RX_PULSE;
      else if (pick == 5) op = OP_TX_PULSE;
      else op = op_type'($urandom_range(3, 7));
      // keep the error flag mostly clear so the lower priorities show
      if (op == OP_ERROR) flag = ($urandom_range(0, 3) == 0);
      else flag = 1'($urandom_range(0, 1));
      send_request(op, flag);
   endtask

   initial begin
      forever begin
         int wait_cycles;
         @(posedge clock);
         if (!reset) begin
            wait_cycles = receiver_idles ? $urandom_range(0, 4) : 0;
            if (long_hold_pending) begin
               long_hold_pending = 1'b0;
               wait_cycles = LONG_HOLD;
            end
            if (wait_cycles > 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
         end
      end
   end

   initial begin
      logic [HOLD_TIME_BITS-1:0] hold;
      logic [PERIOD_BITS-1:0] period;
      int pick;
      board = new();
      settings_used  = 0;
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      long_hold_pending = 1'b0;
      reset          <= 1'b1;
      csr_write      <= 1'b0;
      csr_index      <= CSR_HOLD_TIME;
      csr_wdata      <= '0;
      req_valid      <= 1'b0;
      req_operation  <= OP_TICK;
      req_flag_value <= 1'b0;
      rsp_stall      <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values; flag bit set on tick and pulses must be ignored
      send_request(OP_TICK, 1'b1);
      send_request(OP_RX_PULSE, 1'b1);
      send_request(OP_TX_PULSE, 1'b0);
      send_request(OP_ERROR, 1'b1);
      send_request(OP_STA_MODE, 1'b1);
      send_request(OP_ERROR, 1'b0);
      send_request(OP_AP_MODE, 1'b1);
      send_request(OP_STA_MODE, 1'b0);
      send_request(OP_AP_CLIENT, 1'b1);
      send_request(OP_AP_CLIENT, 1'b0);
      send_request(OP_STA_MODE, 1'b1);
      send_request(OP_STA_LINK, 1'b1);
      send_request(OP_STA_LINK, 1'b0);
      settle();

      // zero hold time and zero period
      configure('0, '0);
      send_request(OP_RX_PULSE, 1'b0);
      send_request(OP_TICK, 1'b0);
      send_request(OP_TICK, 1'b1);
      send_request(OP_AP_MODE, 1'b1);
      settle();

      configure('1, '1);
      send_request(OP_RX_PULSE, 1'b0);
      send_request(OP_TX_PULSE, 1'b1);
      send_request(OP_TICK, 1'b0);
      settle();

      configure(8'd1, 16'd1);
      send_request(OP_TICK, 1'b0);
      send_request(OP_RX_PULSE, 1'b0);
      send_request(OP_TICK, 1'b0);
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         pick = $urandom_range(0, 11);
         if (pick < 2) hold = '1;
         else if (pick < 4) hold = 8'd1;
         else if (pick == 4) hold = '0;
         else hold = 8'($urandom_range(1, 12));
         pick = $urandom_range(0, 11);
         if (pick < 2) period = '1;
         else if (pick < 4) period = 16'd1;
         else if (pick == 4) period = '0;
         else period = 16'($urandom_range(1, 40));
         configure(hold, period);
         sender_idles   = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
         receiver_idles = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
         if (p == 3 || p == 6) long_hold_pending = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) send_random_event();
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests over %0d register settings; %0d colors compared",
               board.requests_seen, settings_used + 1, board.colors_checked);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

@@ activity_status_led_mixer.f @@
rtl/core/aslm_pkg.sv
rtl/core/activity_status_led_mixer.sv
tb/tb.sv
